// ===== sv/dpfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Debug packet framer package
// Shared constants, the command record passed from the front end to the
// back end, and the hex digit lookup.
// ----------------------------------------------------------------------------
package dpfe_pkg;

   // Fixed field widths of the ports.
   localparam int BYTE_W    = 8;
   localparam int PKTLEN_W  = 16;
   localparam int MAXLEN_W  = 16;
   localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 16'd1024;

   // Width of the framed length counter; it saturates at its all-ones value.
   localparam int LENGTH_BITS = 16;
   // The limit compare must hold both the counter and the length register.
   localparam int CMP_W       = ((LENGTH_BITS > MAXLEN_W) ? LENGTH_BITS : MAXLEN_W) + 2;
   localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

   // Framing characters.
   localparam logic [BYTE_W-1:0] CH_START = 8'h24;
   localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
   localparam logic [BYTE_W-1:0] CH_ESC   = 8'h7D;
   localparam logic [BYTE_W-1:0] ESC_XOR  = 8'h20;
   localparam logic [3:0]        NIB_MASK = 4'hF;

   // Trailer length counted by the limit check.
   localparam int TRAILER_LEN = 3;

   // Link bytes one command can produce, in emission order.
   localparam int STEP_START = 0;
   localparam int STEP_ESC   = 1;
   localparam int STEP_DATA  = 2;
   localparam int STEP_HASH  = 3;
   localparam int STEP_HI    = 4;
   localparam int STEP_LO    = 5;
   localparam int NUM_STEPS  = 6;

   // Command queue between front and back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [NUM_STEPS-1:0] step_mask_type;

   typedef struct packed {
      logic              start;     // open the packet with '$'
      logic              esc;       // escape prefix before the data byte
      logic              data_vld;  // a body byte is emitted
      logic [BYTE_W-1:0] data;      // body byte before escaping
      logic              trailer;   // close with '#' and checksum digits
      logic              ovf;       // overflow state seen by the trailer
   } cmd_type;

   function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
      logic [BYTE_W-1:0] ch;
      begin
         if (nib < 4'd10) begin
            ch = 8'h30 + {4'd0, nib};
         end else begin
            ch = 8'h57 + {4'd0, nib};
         end
         return ch;
      end
   endfunction

endpackage

// ===== sv/dpfe_front.sv =====
// ----------------------------------------------------------------------------
// Debug packet framer front end
// Accepts input items, tracks the packet length and overflow state, applies
// the length limit and issues one command per item that produces link bytes.
// ----------------------------------------------------------------------------
module dpfe_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [dpfe_pkg::MAXLEN_W-1:0]      csr_max_packet_len,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [dpfe_pkg::BYTE_W-1:0]        req_in_byte,
   input  logic                               req_mode,
   input  logic                               req_byte_valid,
   input  logic                               req_last_item,
   output logic                               cmd_push,
   output dpfe_pkg::cmd_type                  cmd_data,
   input  logic                               cmd_full
);

   logic [dpfe_pkg::MAXLEN_W-1:0]    max_len_ff;
   logic                             in_packet_ff, in_packet_in;
   logic [dpfe_pkg::LENGTH_BITS-1:0] cnt_ff, cnt_in;
   logic                             ovf_ff, ovf_in;

   logic                             accept;
   logic                             start;
   logic [dpfe_pkg::LENGTH_BITS-1:0] cnt0;
   logic                             ovf0;
   logic                             needs_esc;
   logic [dpfe_pkg::CMP_W-1:0]       need;
   logic [dpfe_pkg::CMP_W-1:0]       grown;
   logic                             fits;
   logic                             body_ok;
   logic                             dropped;

   assign req_full = cmd_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      start     = !in_packet_ff;
      cnt0      = start ? dpfe_pkg::LENGTH_BITS'(1) : cnt_ff;
      ovf0      = start ? 1'b0 : ovf_ff;
      needs_esc = req_mode && ((req_in_byte == dpfe_pkg::CH_START) ||
                               (req_in_byte == dpfe_pkg::CH_HASH)  ||
                               (req_in_byte == dpfe_pkg::CH_ESC));
      need      = needs_esc ? dpfe_pkg::CMP_W'(2) : dpfe_pkg::CMP_W'(1);
      grown     = dpfe_pkg::CMP_W'(cnt0) + need;
      // The body byte must leave room for the three trailer bytes.
      fits      = (grown + dpfe_pkg::CMP_W'(dpfe_pkg::TRAILER_LEN)) <=
                  dpfe_pkg::CMP_W'(max_len_ff);
      body_ok   = req_byte_valid && !ovf0 && fits;
      dropped   = req_byte_valid && !ovf0 && !fits;

      if (body_ok) begin
         cnt_in = (grown > dpfe_pkg::CMP_W'(dpfe_pkg::CNT_MAX)) ?
                  dpfe_pkg::CNT_MAX : dpfe_pkg::LENGTH_BITS'(grown);
      end else begin
         cnt_in = cnt0;
      end
      ovf_in       = ovf0 || dropped;
      in_packet_in = !req_last_item;

      cmd_data.start    = start;
      cmd_data.esc      = body_ok && needs_esc;
      cmd_data.data_vld = body_ok;
      cmd_data.data     = req_in_byte;
      cmd_data.trailer  = req_last_item;
      cmd_data.ovf      = ovf_in;
   end

   // Items that produce no link byte never enter the queue.
   assign cmd_push = accept && (start || body_ok || req_last_item);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= dpfe_pkg::MAXLEN_RESET;
         in_packet_ff <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            max_len_ff <= csr_max_packet_len;
         end
         if (accept) begin
            in_packet_ff <= in_packet_in;
            ovf_ff       <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== sv/dpfe_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// Debug packet framer command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module dpfe_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dpfe_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output dpfe_pkg::cmd_type head,
   output logic              empty
);

   dpfe_pkg::cmd_type entry_ff [dpfe_pkg::QUEUE_DEPTH];
   logic [dpfe_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [dpfe_pkg::QCNT_W-1:0] count_ff;
   logic                        do_push, do_pop;

   assign full    = (count_ff == dpfe_pkg::QCNT_W'(dpfe_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == dpfe_pkg::QPTR_W'(dpfe_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == dpfe_pkg::QPTR_W'(dpfe_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/dpfe_back.sv =====
// ----------------------------------------------------------------------------
// Debug packet framer back end
// Expands each command into link bytes, one per cycle unless stalled, keeping
// packet length and checksum, and holds the oldest byte in an output register.
// ----------------------------------------------------------------------------
module dpfe_back (
   input  logic                               clock,
   input  logic                               reset,
   input  dpfe_pkg::cmd_type                  cmd_head,
   input  logic                               cmd_empty,
   output logic                               cmd_pop,
   output logic [dpfe_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                               rsp_end_of_packet,
   output logic                               rsp_overflow,
   output logic [dpfe_pkg::PKTLEN_W-1:0]      rsp_packet_length,
   output logic                               rsp_empty,
   input  logic                               rsp_pop
);

   dpfe_pkg::cmd_type                work_ff;
   dpfe_pkg::step_mask_type          mask_ff, mask_in;
   logic [dpfe_pkg::LENGTH_BITS-1:0] len_ff, len_in;
   logic [dpfe_pkg::BYTE_W-1:0]      sum_ff, sum_in;
   logic                             out_vld_ff;
   logic [dpfe_pkg::BYTE_W-1:0]      out_byte_ff, out_byte_in;
   logic                             out_eop_ff, out_eop_in;
   logic                             out_ovf_ff, out_ovf_in;
   logic [dpfe_pkg::LENGTH_BITS-1:0] out_len_ff;

   dpfe_pkg::step_mask_type          sel;
   dpfe_pkg::step_mask_type          mask_left;
   dpfe_pkg::step_mask_type          head_mask;
   logic                             out_load;
   logic                             advance;
   logic                             in_body;

   assign out_load = !out_vld_ff || rsp_pop;
   assign advance  = out_load && (mask_ff != '0);
   // Lowest pending step is the next link byte.
   assign sel      = mask_ff & (~mask_ff + 1'b1);

   always_comb begin
      head_mask = '0;
      head_mask[dpfe_pkg::STEP_START] = cmd_head.start;
      head_mask[dpfe_pkg::STEP_ESC]   = cmd_head.esc;
      head_mask[dpfe_pkg::STEP_DATA]  = cmd_head.data_vld;
      head_mask[dpfe_pkg::STEP_HASH]  = cmd_head.trailer;
      head_mask[dpfe_pkg::STEP_HI]    = cmd_head.trailer;
      head_mask[dpfe_pkg::STEP_LO]    = cmd_head.trailer;

      mask_left = advance ? (mask_ff & ~sel) : mask_ff;
      cmd_pop   = (mask_left == '0) && !cmd_empty;
      mask_in   = cmd_pop ? head_mask : mask_left;
   end

   always_comb begin
      out_byte_in = dpfe_pkg::CH_START;
      out_eop_in  = 1'b0;
      out_ovf_in  = 1'b0;
      in_body     = 1'b0;
      if (sel[dpfe_pkg::STEP_START]) begin
         out_byte_in = dpfe_pkg::CH_START;
      end else if (sel[dpfe_pkg::STEP_ESC]) begin
         out_byte_in = dpfe_pkg::CH_ESC;
         in_body     = 1'b1;
      end else if (sel[dpfe_pkg::STEP_DATA]) begin
         out_byte_in = work_ff.esc ? (work_ff.data ^ dpfe_pkg::ESC_XOR) : work_ff.data;
         in_body     = 1'b1;
      end else if (sel[dpfe_pkg::STEP_HASH]) begin
         out_byte_in = dpfe_pkg::CH_HASH;
         out_ovf_in  = work_ff.ovf;
      end else if (sel[dpfe_pkg::STEP_HI]) begin
         out_byte_in = dpfe_pkg::hex_digit(sum_ff[7:4] & dpfe_pkg::NIB_MASK);
         out_ovf_in  = work_ff.ovf;
      end else begin
         out_byte_in = dpfe_pkg::hex_digit(sum_ff[3:0] & dpfe_pkg::NIB_MASK);
         out_eop_in  = 1'b1;
         out_ovf_in  = work_ff.ovf;
      end

      // The opening marker restarts both the length and the checksum.
      if (sel[dpfe_pkg::STEP_START]) begin
         len_in = dpfe_pkg::LENGTH_BITS'(1);
         sum_in = '0;
      end else begin
         len_in = (len_ff == dpfe_pkg::CNT_MAX) ? len_ff : len_ff + 1'b1;
         sum_in = in_body ? (sum_ff + out_byte_in) : sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= '0;
         out_vld_ff <= 1'b0;
         len_ff     <= '0;
         sum_ff     <= '0;
      end else begin
         mask_ff <= mask_in;
         if (advance) begin
            len_ff <= len_in;
            sum_ff <= sum_in;
         end
         if (out_load) begin
            out_vld_ff <= advance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         work_ff <= cmd_head;
      end
      if (advance) begin
         out_byte_ff <= out_byte_in;
         out_eop_ff  <= out_eop_in;
         out_ovf_ff  <= out_ovf_in;
         out_len_ff  <= len_in;
      end
   end

   assign rsp_empty         = !out_vld_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_end_of_packet = out_eop_ff;
   assign rsp_overflow      = out_ovf_ff;
   assign rsp_packet_length = dpfe_pkg::PKTLEN_W'(out_len_ff);

endmodule

// ===== sv/debug_packet_framer_escaped.sv =====
// ----------------------------------------------------------------------------
// Debug packet framer with escaping
// Frames packets as '$' body '#' and two hex checksum digits, escaping
// '$', '#' and '}' in binary mode and enforcing a maximum framed length.
//
//   Channel   Ports                         Moves
//   req       req_push / req_full           one item per transfer
//   rsp       rsp_pop / rsp_empty           one framed link byte per transfer
//   csr       csr_we                        max_packet_len, written at once
//
// The back end emits one link byte per cycle while rsp is not stalled; an item
// produces 1 to 6 link bytes, 2 for an escaped body byte.
// The front end takes an item per cycle while the two-entry command queue
// has room; items that produce no link byte never enter the queue.
// An item is held in the queue, then the back end, then the output register.
// Reset is synchronous; it empties the queue and output, closes any packet
// and sets max_packet_len to 1024. A stall on rsp backs up into req_full.
// ----------------------------------------------------------------------------
module debug_packet_framer_escaped (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [dpfe_pkg::MAXLEN_W-1:0]      csr_max_packet_len,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [dpfe_pkg::BYTE_W-1:0]        req_in_byte,
   input  logic                               req_mode,
   input  logic                               req_byte_valid,
   input  logic                               req_last_item,
   output logic [dpfe_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                               rsp_end_of_packet,
   output logic                               rsp_overflow,
   output logic [dpfe_pkg::PKTLEN_W-1:0]      rsp_packet_length,
   output logic                               rsp_empty,
   input  logic                               rsp_pop
);

   logic              cmd_push;
   dpfe_pkg::cmd_type cmd_data;
   logic              cmd_full;
   logic              cmd_pop;
   dpfe_pkg::cmd_type cmd_head;
   logic              cmd_empty;

   dpfe_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_max_packet_len (csr_max_packet_len),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_in_byte        (req_in_byte),
      .req_mode           (req_mode),
      .req_byte_valid     (req_byte_valid),
      .req_last_item      (req_last_item),
      .cmd_push           (cmd_push),
      .cmd_data           (cmd_data),
      .cmd_full           (cmd_full)
   );

   dpfe_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty)
   );

   dpfe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_head          (cmd_head),
      .cmd_empty         (cmd_empty),
      .cmd_pop           (cmd_pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_packet (rsp_end_of_packet),
      .rsp_overflow      (rsp_overflow),
      .rsp_packet_length (rsp_packet_length),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop)
   );

endmodule

// ===== sv/dpfe_checker.sv =====
// ----------------------------------------------------------------------------
// Debug packet framer port checker
// Watches the top level ports for framing and handshake consistency.
// ----------------------------------------------------------------------------
module dpfe_checker (
   input logic                               clock,
   input logic                               reset,
   input logic [dpfe_pkg::BYTE_W-1:0]        rsp_out_byte,
   input logic                               rsp_end_of_packet,
   input logic                               rsp_overflow,
   input logic [dpfe_pkg::PKTLEN_W-1:0]      rsp_packet_length,
   input logic                               rsp_empty,
   input logic                               rsp_pop
);

   logic rsp_xfer;
   logic after_eop_ff;

   assign rsp_xfer = rsp_pop && !rsp_empty;

   // Set while the next transferred byte must open a new packet.
   always_ff @(posedge clock) begin
      if (reset) begin
         after_eop_ff <= 1'b1;
      end else if (rsp_xfer) begin
         after_eop_ff <= rsp_end_of_packet;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("output not empty after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte) &&
                                    $stable(rsp_packet_length)))
      else $error("stalled output byte changed");

   a_open_packet: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && after_eop_ff) |->
         (rsp_out_byte == dpfe_pkg::CH_START && rsp_packet_length == 16'd1 &&
          !rsp_overflow && !rsp_end_of_packet))
      else $error("packet does not open with the start marker");

   a_eop_digit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_end_of_packet) |->
         ((rsp_out_byte >= 8'h30 && rsp_out_byte <= 8'h39) ||
          (rsp_out_byte >= 8'h61 && rsp_out_byte <= 8'h66)))
      else $error("last byte of packet is not a hex digit");

endmodule

bind debug_packet_framer_escaped dpfe_checker u_dpfe_checker (.*);
